FILE: hdl/dstu_pkg.sv
// Shared types and constants for the detector status table update block.
// Depends on nothing; used by dstu_ctrl, dstu_dp, the top level and the testbench.
package dstu_pkg;

    localparam int CHANNELS_PER_GROUP = 8;
    localparam int CHANNEL_COUNT      = 1024;
    localparam int IX_W               = $clog2(CHANNEL_COUNT);
    localparam int CHAN_W             = 8;
    localparam int GROUP_W            = 11;
    localparam int WIDE_W             = GROUP_W + $clog2(CHANNELS_PER_GROUP) + 2;
    localparam int OUT_IX_W           = 10;

    localparam logic [3:0] LIMIT_RESET = 4'd1;

    localparam logic [7:0] KIND_NONE    = 8'h00;
    localparam logic [7:0] KIND_CURRENT = 8'h01;
    localparam logic [7:0] KIND_TEMP    = 8'h02;

    localparam logic [1:0] REC_NONE    = 2'd0;
    localparam logic [1:0] REC_CURRENT = 2'd1;
    localparam logic [1:0] REC_TEMP    = 2'd2;

    localparam logic [7:0] CODE_NORMAL   = 8'h00;
    localparam logic [7:0] CODE_ALARM    = 8'h01;
    localparam logic [7:0] CODE_REPORT   = 8'h02;
    localparam logic [7:0] CODE_FAULT    = 8'h03;
    localparam logic [7:0] CODE_SETPOINT = 8'hF2;

    // One channel record, one memory word.
    typedef struct packed {
        logic [1:0]  kind;
        logic        normal;
        logic        alarm;
        logic        fault;
        logic [3:0]  cur_rep;
        logic [3:0]  tmp_rep;
        logic [15:0] cur_read;
        logic [7:0]  tmp_read;
        logic        cur_lock;
        logic [15:0] cur_held;
        logic        tmp_lock;
        logic [7:0]  tmp_held;
        logic [15:0] cur_set;
        logic [7:0]  tmp_set;
    } t_rec;

    // Controller to datapath.
    typedef struct packed {
        logic clr_wr;   // write zero record at sweep address, step sweep
        logic accept;   // capture input beat, read record
        logic commit;   // write back record, load result register
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic clr_last; // sweep at final entry
        logic out_free; // result register can take a new beat
    } t_sts;

endpackage

FILE: hdl/dstu_ctrl.sv
// Controller FSM: clearing sweep after reset, then accept / update per item.
// Depends on dstu_pkg.
module dstu_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  dstu_pkg::t_sts i_sts,
    output dstu_pkg::t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_UPD   = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state      = r_state;
        o_cmd.clr_wr = 1'b0;
        o_cmd.accept = 1'b0;
        o_cmd.commit = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_UPD;
                end
            end
            S_UPD: begin
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: hdl/dstu_dp.sv
// Datapath: record memory, index decode, record update and result register.
// Depends on dstu_pkg.
module dstu_dp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  dstu_pkg::t_cmd               i_cmd,
    output dstu_pkg::t_sts               o_sts,
    input  logic                         i_cfg_valid,
    input  logic [3:0]                   i_cfg_data,
    input  logic [dstu_pkg::GROUP_W-1:0] i_node_group,
    input  logic [dstu_pkg::CHAN_W-1:0]  i_channel,
    input  logic [7:0]                   i_sensor_kind,
    input  logic [7:0]                   i_report_code,
    input  logic [7:0]                   i_value_high,
    input  logic [7:0]                   i_value_low,
    input  logic                         i_out_stall,
    output logic                         o_out_valid,
    output logic [dstu_pkg::OUT_IX_W-1:0] o_channel_index,
    output logic                         o_dropped,
    output logic [1:0]                   o_record_kind,
    output logic                         o_normal_bit,
    output logic                         o_alarm_bit,
    output logic                         o_fault_bit,
    output logic [15:0]                  o_live_value,
    output logic                         o_alarm_value_held,
    output logic [15:0]                  o_held_alarm_value,
    output logic [15:0]                  o_alarm_setpoint
);

    dstu_pkg::t_rec mem [dstu_pkg::CHANNEL_COUNT];

    logic [3:0]                r_limit;
    logic [dstu_pkg::IX_W-1:0] r_clr;
    logic [dstu_pkg::IX_W-1:0] r_ix;
    logic                      r_drop;
    logic [7:0]                r_kind;
    logic [7:0]                r_code;
    logic [15:0]               r_word;
    dstu_pkg::t_rec            r_rd;

    logic [dstu_pkg::WIDE_W-1:0] ix_wide;
    logic                        in_drop;
    dstu_pkg::t_rec              n_rec;
    logic [4:0]                  rep_next;
    logic                        raise;

    logic                         r_out_valid;
    logic [dstu_pkg::OUT_IX_W-1:0] r_out_ix;
    logic                         r_out_drop;
    logic [1:0]                   r_out_kind;
    logic                         r_out_n;
    logic                         r_out_a;
    logic                         r_out_f;
    logic [15:0]                  r_out_live;
    logic                         r_out_lock;
    logic [15:0]                  r_out_held;
    logic [15:0]                  r_out_set;

    logic [15:0] n_live;
    logic        n_lock;
    logic [15:0] n_held;
    logic [15:0] n_set;

    // index decode on the incoming beat
    assign ix_wide = (dstu_pkg::WIDE_W'(i_node_group) - dstu_pkg::WIDE_W'(1))
                     * dstu_pkg::WIDE_W'(dstu_pkg::CHANNELS_PER_GROUP)
                     + dstu_pkg::WIDE_W'(i_channel);
    assign in_drop = (i_node_group == '0)
                  || (dstu_pkg::WIDE_W'(i_channel) >=
                      dstu_pkg::WIDE_W'(dstu_pkg::CHANNELS_PER_GROUP))
                  || (ix_wide >= dstu_pkg::WIDE_W'(dstu_pkg::CHANNEL_COUNT));

    assign o_sts.clr_last = (r_clr == dstu_pkg::IX_W'(dstu_pkg::CHANNEL_COUNT - 1));
    assign o_sts.out_free = !r_out_valid || !i_out_stall;

    // record update
    always_comb begin
        n_rec    = r_rd;
        rep_next = 5'd0;
        raise    = 1'b0;
        unique case (r_kind)
            dstu_pkg::KIND_NONE: begin
                n_rec.kind = dstu_pkg::REC_NONE;
            end
            dstu_pkg::KIND_CURRENT: begin
                n_rec.kind = dstu_pkg::REC_CURRENT;
                case (r_code)
                    dstu_pkg::CODE_ALARM, dstu_pkg::CODE_REPORT: begin
                        rep_next = {1'b0, r_rd.cur_rep} + 5'd1;
                        raise    = (rep_next > {1'b0, r_limit});
                        if (raise) begin
                            n_rec.cur_rep = 4'd0;
                            n_rec.normal  = 1'b0;
                            n_rec.alarm   = 1'b1;
                            n_rec.fault   = 1'b0;
                            if (!r_rd.cur_lock) begin
                                n_rec.cur_lock = 1'b1;
                                n_rec.cur_held = r_word;
                            end
                        end else begin
                            n_rec.cur_rep = rep_next[3:0];
                        end
                        n_rec.cur_read = r_word;
                    end
                    dstu_pkg::CODE_NORMAL: begin
                        n_rec.cur_read = r_word;
                        n_rec.normal   = 1'b1;
                        n_rec.alarm    = 1'b0;
                        n_rec.fault    = 1'b0;
                    end
                    dstu_pkg::CODE_FAULT: begin
                        n_rec.cur_read = 16'd0;
                        n_rec.normal   = 1'b0;
                        n_rec.fault    = 1'b1;
                    end
                    dstu_pkg::CODE_SETPOINT: begin
                        n_rec.cur_set = r_word;
                    end
                    default: begin
                    end
                endcase
            end
            dstu_pkg::KIND_TEMP: begin
                n_rec.kind = dstu_pkg::REC_TEMP;
                case (r_code)
                    dstu_pkg::CODE_ALARM, dstu_pkg::CODE_REPORT: begin
                        rep_next = {1'b0, r_rd.tmp_rep} + 5'd1;
                        raise    = (rep_next > {1'b0, r_limit});
                        if (raise) begin
                            n_rec.tmp_rep = 4'd0;
                            n_rec.normal  = 1'b0;
                            n_rec.alarm   = 1'b1;
                            n_rec.fault   = 1'b0;
                            if (!r_rd.tmp_lock) begin
                                n_rec.tmp_lock = 1'b1;
                                n_rec.tmp_held = r_word[7:0];
                            end
                        end else begin
                            n_rec.tmp_rep = rep_next[3:0];
                        end
                        n_rec.tmp_read = r_word[7:0];
                    end
                    dstu_pkg::CODE_NORMAL: begin
                        n_rec.tmp_read = r_word[7:0];
                        n_rec.normal   = 1'b1;
                        n_rec.alarm    = 1'b0;
                        n_rec.fault    = 1'b0;
                    end
                    dstu_pkg::CODE_FAULT: begin
                        n_rec.tmp_read = 8'd0;
                        n_rec.normal   = 1'b0;
                        n_rec.fault    = 1'b1;
                    end
                    dstu_pkg::CODE_SETPOINT: begin
                        n_rec.tmp_set = r_word[7:0];
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    // per-kind view of the updated record
    always_comb begin
        n_live = 16'd0;
        n_lock = 1'b0;
        n_held = 16'd0;
        n_set  = 16'd0;
        case (n_rec.kind)
            dstu_pkg::REC_CURRENT: begin
                n_live = n_rec.cur_read;
                n_lock = n_rec.cur_lock;
                n_held = n_rec.cur_held;
                n_set  = n_rec.cur_set;
            end
            dstu_pkg::REC_TEMP: begin
                n_live = {8'd0, n_rec.tmp_read};
                n_lock = n_rec.tmp_lock;
                n_held = {8'd0, n_rec.tmp_held};
                n_set  = {8'd0, n_rec.tmp_set};
            end
            default: begin
            end
        endcase
    end

    // record memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_wr) begin
            mem[r_clr] <= '0;
        end else if (i_cmd.commit && !r_drop) begin
            mem[r_ix] <= n_rec;
        end
        if (i_cmd.accept) begin
            r_rd <= mem[ix_wide[dstu_pkg::IX_W-1:0]];
        end
    end

    // input beat capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_ix   <= ix_wide[dstu_pkg::IX_W-1:0];
            r_drop <= in_drop;
            r_kind <= i_sensor_kind;
            r_code <= i_report_code;
            r_word <= {i_value_high, i_value_low};
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit     <= dstu_pkg::LIMIT_RESET;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_limit <= i_cfg_data;
            end
            if (i_cmd.clr_wr) begin
                r_clr <= r_clr + dstu_pkg::IX_W'(1);
            end
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            if (r_drop) begin
                r_out_ix   <= '0;
                r_out_drop <= 1'b1;
                r_out_kind <= 2'd0;
                r_out_n    <= 1'b0;
                r_out_a    <= 1'b0;
                r_out_f    <= 1'b0;
                r_out_live <= 16'd0;
                r_out_lock <= 1'b0;
                r_out_held <= 16'd0;
                r_out_set  <= 16'd0;
            end else begin
                r_out_ix   <= dstu_pkg::OUT_IX_W'(r_ix);
                r_out_drop <= 1'b0;
                r_out_kind <= n_rec.kind;
                r_out_n    <= n_rec.normal;
                r_out_a    <= n_rec.alarm;
                r_out_f    <= n_rec.fault;
                r_out_live <= n_live;
                r_out_lock <= n_lock;
                r_out_held <= n_held;
                r_out_set  <= n_set;
            end
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_channel_index    = r_out_ix;
    assign o_dropped          = r_out_drop;
    assign o_record_kind      = r_out_kind;
    assign o_normal_bit       = r_out_n;
    assign o_alarm_bit        = r_out_a;
    assign o_fault_bit        = r_out_f;
    assign o_live_value       = r_out_live;
    assign o_alarm_value_held = r_out_lock;
    assign o_held_alarm_value = r_out_held;
    assign o_alarm_setpoint   = r_out_set;

endmodule

FILE: hdl/detector_status_table_update_core.sv
// Detector status table update, top level. Depends on dstu_pkg, dstu_ctrl, dstu_dp.
// Per item: the input beat is captured and its record read, then the record is
// written back and the result register loaded; this waits while the result
// register is stalled. No new item is taken until the write-back is done.
// Reset: synchronous, active low; then a clearing pass (one record per cycle,
// CHANNEL_COUNT in all) with input stalled. Repeat limit resets to 1.
module detector_status_table_update_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: repeat limit
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [3:0]  i_cfg_data,
    // report input
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [10:0] i_node_group,
    input  logic [7:0]  i_channel,
    input  logic [7:0]  i_sensor_kind,
    input  logic [7:0]  i_report_code,
    input  logic [7:0]  i_value_high,
    input  logic [7:0]  i_value_low,
    // updated record output
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [9:0]  o_channel_index,
    output logic        o_dropped,
    output logic [1:0]  o_record_kind,
    output logic        o_normal_bit,
    output logic        o_alarm_bit,
    output logic        o_fault_bit,
    output logic [15:0] o_live_value,
    output logic        o_alarm_value_held,
    output logic [15:0] o_held_alarm_value,
    output logic [15:0] o_alarm_setpoint
);

    dstu_pkg::t_cmd cmd;
    dstu_pkg::t_sts sts;

    // Config writes must only arrive while idle (not enforced); port always ready.
    assign o_cfg_ready = 1'b1;

    // FSM: clear sweep -> idle -> update (waits on a stalled result beat).
    dstu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Record memory, update logic and result register. The result register
    // decouples the output: a finished beat may wait while the next is taken.
    dstu_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .i_cfg_valid        (i_cfg_valid),
        .i_cfg_data         (i_cfg_data),
        .i_node_group       (i_node_group),
        .i_channel          (i_channel),
        .i_sensor_kind      (i_sensor_kind),
        .i_report_code      (i_report_code),
        .i_value_high       (i_value_high),
        .i_value_low        (i_value_low),
        .i_out_stall        (i_out_stall),
        .o_out_valid        (o_out_valid),
        .o_channel_index    (o_channel_index),
        .o_dropped          (o_dropped),
        .o_record_kind      (o_record_kind),
        .o_normal_bit       (o_normal_bit),
        .o_alarm_bit        (o_alarm_bit),
        .o_fault_bit        (o_fault_bit),
        .o_live_value       (o_live_value),
        .o_alarm_value_held (o_alarm_value_held),
        .o_held_alarm_value (o_held_alarm_value),
        .o_alarm_setpoint   (o_alarm_setpoint)
    );

endmodule

FILE: tb/tb_detector_status_table_update_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for detector_status_table_update_core: holds a scoreboard class
// with its own record table model. Depends on dstu_pkg and the core RTL only.
module tb_detector_status_table_update_core;

    // One report beat as presented on the input payload ports.
    typedef struct packed {
        logic [10:0] node_group;
        logic [7:0]  chan;
        logic [7:0]  kind;
        logic [7:0]  code;
        logic [7:0]  hi;
        logic [7:0]  lo;
    } t_report;

    // One updated-record beat as seen on the output payload ports.
    typedef struct packed {
        logic [9:0]  ix;
        logic        dropped;
        logic [1:0]  kind;
        logic        normal;
        logic        alarm;
        logic        fault;
        logic [15:0] live;
        logic        held_flag;
        logic [15:0] held;
        logic [15:0] setpoint;
    } t_rec_beat;

    // Scoreboard: mirrors the channel record table and the repeat limit, predicts the
    // record beat for every accepted report and checks beats in arrival order.
    class record_table_model;
        dstu_pkg::t_rec rec_tab[dstu_pkg::CHANNEL_COUNT];
        logic [3:0]     repeat_limit;
        t_rec_beat      pending_q[$];
        int             mismatch_cnt;

        function new();
            foreach (rec_tab[i]) rec_tab[i] = '0;
            repeat_limit = dstu_pkg::LIMIT_RESET;
            mismatch_cnt = 0;
        endfunction

        // One more alarm report; returns 1 when the limit is passed.
        function bit bump_repeat(inout logic [3:0] cnt);
            logic [4:0] nxt;
            nxt = {1'b0, cnt} + 5'd1;
            if (nxt > {1'b0, repeat_limit}) begin
                cnt = 4'd0;
                return 1'b1;
            end
            cnt = nxt[3:0];
            return 1'b0;
        endfunction

        // Applies an accepted report to the table and queues the expected beat.
        // Returns 1 when the report actually addressed a record with a known kind.
        function bit note_report(t_report r);
            int             wide;
            dstu_pkg::t_rec rec;
            t_rec_beat      want;
            logic [15:0]    word;

            want = '0;
            word = {r.hi, r.lo};
            wide = (int'(r.node_group) - 1) * dstu_pkg::CHANNELS_PER_GROUP + int'(r.chan);
            if (r.node_group == 0 || r.chan >= dstu_pkg::CHANNELS_PER_GROUP
                || wide >= dstu_pkg::CHANNEL_COUNT)
            begin
                want.dropped = 1'b1;
                pending_q.push_back(want);
                return 1'b0;
            end

            rec = rec_tab[wide];
            case (r.kind)
                dstu_pkg::KIND_NONE: begin
                    rec.kind = dstu_pkg::REC_NONE;
                end
                dstu_pkg::KIND_CURRENT: begin
                    rec.kind = dstu_pkg::REC_CURRENT;
                    case (r.code)
                        dstu_pkg::CODE_ALARM, dstu_pkg::CODE_REPORT: begin
                            if (bump_repeat(rec.cur_rep)) begin
                                {rec.normal, rec.alarm, rec.fault} = 3'b010;
                                if (!rec.cur_lock) begin
                                    rec.cur_lock = 1'b1;
                                    rec.cur_held = word;
                                end
                            end
                            rec.cur_read = word;
                        end
                        dstu_pkg::CODE_NORMAL: begin
                            rec.cur_read = word;
                            {rec.normal, rec.alarm, rec.fault} = 3'b100;
                        end
                        dstu_pkg::CODE_FAULT: begin
                            rec.cur_read = '0;
                            rec.normal   = 1'b0;
                            rec.fault    = 1'b1;
                        end
                        dstu_pkg::CODE_SETPOINT: rec.cur_set = word;
                        default: ;
                    endcase
                end
                dstu_pkg::KIND_TEMP: begin
                    rec.kind = dstu_pkg::REC_TEMP;
                    case (r.code)
                        dstu_pkg::CODE_ALARM, dstu_pkg::CODE_REPORT: begin
                            if (bump_repeat(rec.tmp_rep)) begin
                                {rec.normal, rec.alarm, rec.fault} = 3'b010;
                                if (!rec.tmp_lock) begin
                                    rec.tmp_lock = 1'b1;
                                    rec.tmp_held = r.lo;
                                end
                            end
                            rec.tmp_read = r.lo;
                        end
                        dstu_pkg::CODE_NORMAL: begin
                            rec.tmp_read = r.lo;
                            {rec.normal, rec.alarm, rec.fault} = 3'b100;
                        end
                        dstu_pkg::CODE_FAULT: begin
                            rec.tmp_read = '0;
                            rec.normal   = 1'b0;
                            rec.fault    = 1'b1;
                        end
                        dstu_pkg::CODE_SETPOINT: rec.tmp_set = r.lo;
                        default: ;
                    endcase
                end
                default: ;
            endcase
            rec_tab[wide] = rec;

            want.ix     = wide[9:0];
            want.kind   = rec.kind;
            want.normal = rec.normal;
            want.alarm  = rec.alarm;
            want.fault  = rec.fault;
            if (rec.kind == dstu_pkg::REC_CURRENT) begin
                want.live      = rec.cur_read;
                want.held_flag = rec.cur_lock;
                want.held      = rec.cur_held;
                want.setpoint  = rec.cur_set;
            end else if (rec.kind == dstu_pkg::REC_TEMP) begin
                want.live      = {8'h00, rec.tmp_read};
                want.held_flag = rec.tmp_lock;
                want.held      = {8'h00, rec.tmp_held};
                want.setpoint  = {8'h00, rec.tmp_set};
            end
            pending_q.push_back(want);
            return r.kind <= dstu_pkg::KIND_TEMP;
        endfunction

        // One line per mismatch, each one counted.
        task report_mismatch(string msg);
            mismatch_cnt++;
            $display("%t mismatch: %s", $realtime, msg);
        endtask

        task cmp_field(string name, logic [15:0] got_v, logic [15:0] want_v, logic [9:0] ix);
            if (got_v !== want_v)
                report_mismatch($sformatf("record %0d field %s got %h want %h",
                                          ix, name, got_v, want_v));
        endtask

        task check_result(t_rec_beat got);
            t_rec_beat want;
            if (pending_q.size() == 0) begin
                report_mismatch($sformatf("result beat for record %0d with nothing outstanding",
                                          got.ix));
                return;
            end
            want = pending_q.pop_front();
            cmp_field("channel_index",    16'(got.ix),        16'(want.ix),        want.ix);
            cmp_field("dropped",          16'(got.dropped),   16'(want.dropped),   want.ix);
            cmp_field("record_kind",      16'(got.kind),      16'(want.kind),      want.ix);
            cmp_field("normal_bit",       16'(got.normal),    16'(want.normal),    want.ix);
            cmp_field("alarm_bit",        16'(got.alarm),     16'(want.alarm),     want.ix);
            cmp_field("fault_bit",        16'(got.fault),     16'(want.fault),     want.ix);
            cmp_field("live_value",       got.live,           want.live,           want.ix);
            cmp_field("alarm_value_held", 16'(got.held_flag), 16'(want.held_flag), want.ix);
            cmp_field("held_alarm_value", got.held,           want.held,           want.ix);
            cmp_field("alarm_setpoint",   got.setpoint,       want.setpoint,       want.ix);
        endtask
    endclass

    // ---------------------------------------------------------------- signals
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [3:0]  cfg_data = '0;
    logic        in_valid = 1'b0;
    t_report     in_beat = '0;
    logic        out_stall = 1'b0;

    wire         o_cfg_ready;
    wire         o_in_stall;
    wire         o_out_valid;
    wire  [9:0]  o_channel_index;
    wire         o_dropped;
    wire  [1:0]  o_record_kind;
    wire         o_normal_bit;
    wire         o_alarm_bit;
    wire         o_fault_bit;
    wire  [15:0] o_live_value;
    wire         o_alarm_value_held;
    wire  [15:0] o_held_alarm_value;
    wire  [15:0] o_alarm_setpoint;

    record_table_model sb = new();

    bit idle_on = 1'b1;     // random gaps on both sides when set
    int counted = 0;        // reports that hit a record with a known kind
    int stall_left = 0;

    detector_status_table_update_core uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_data         (cfg_data),
        .i_in_valid         (in_valid),
        .o_in_stall         (o_in_stall),
        .i_node_group       (in_beat.node_group),
        .i_channel          (in_beat.chan),
        .i_sensor_kind      (in_beat.kind),
        .i_report_code      (in_beat.code),
        .i_value_high       (in_beat.hi),
        .i_value_low        (in_beat.lo),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (out_stall),
        .o_channel_index    (o_channel_index),
        .o_dropped          (o_dropped),
        .o_record_kind      (o_record_kind),
        .o_normal_bit       (o_normal_bit),
        .o_alarm_bit        (o_alarm_bit),
        .o_fault_bit        (o_fault_bit),
        .o_live_value       (o_live_value),
        .o_alarm_value_held (o_alarm_value_held),
        .o_held_alarm_value (o_held_alarm_value),
        .o_alarm_setpoint   (o_alarm_setpoint)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Hard stop, well clear of the slowest legal run (clearing pass plus every beat
    // taking the longest gap and the longest stall).
    initial begin
        #6_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Gap length: mostly none or short, the odd long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Result side: a beat moves on an edge where valid is high and stall was low.
    // Values are read before this edge's updates land, so ordering is race free.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !out_stall)
            sb.check_result('{o_channel_index, o_dropped, o_record_kind, o_normal_bit,
                              o_alarm_bit, o_fault_bit, o_live_value, o_alarm_value_held,
                              o_held_alarm_value, o_alarm_setpoint});
        if (stall_left != 0) begin
            stall_left--;
        end else begin
            stall_left = pick_gap();
            out_stall <= (stall_left != 0);
        end
    end

    // Report beat addressed to a table index, value bytes given.
    function automatic t_report at_index(int ix, logic [7:0] kind, logic [7:0] code,
                                         logic [7:0] hi, logic [7:0] lo);
        t_report r;
        r.node_group = 11'(ix / dstu_pkg::CHANNELS_PER_GROUP + 1);
        r.chan       = 8'(ix % dstu_pkg::CHANNELS_PER_GROUP);
        r.kind       = kind;
        r.code       = code;
        r.hi         = hi;
        r.lo         = lo;
        return r;
    endfunction

    // Code mix: alarm_pct percent alarm/report, the rest spread over the others.
    function automatic logic [7:0] pick_code(int alarm_pct);
        if ($urandom_range(0, 99) < alarm_pct)
            return $urandom_range(0, 1) ? dstu_pkg::CODE_ALARM : dstu_pkg::CODE_REPORT;
        case ($urandom_range(0, 4))
            0: return dstu_pkg::CODE_NORMAL;
            1: return dstu_pkg::CODE_FAULT;
            2: return dstu_pkg::CODE_SETPOINT;
            3: return 8'($urandom);
            default: return dstu_pkg::CODE_NORMAL;
        endcase
    endfunction

    function automatic logic [7:0] pick_kind();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return dstu_pkg::KIND_NONE;
        if (r < 50) return dstu_pkg::KIND_CURRENT;
        if (r < 90) return dstu_pkg::KIND_TEMP;
        return 8'($urandom_range(3, 255));
    endfunction

    // Every call starts and ends just after a rising edge. Valid is only dropped
    // when a gap is wanted, so back-to-back beats never see a low/high pair in one step.
    task automatic send_report(input t_report r);
        int gap;
        gap = pick_gap();
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_beat  <= r;
        do @(posedge i_clk); while (o_in_stall);
        if (sb.note_report(r)) counted++;
    endtask

    // Stop sending and wait until every predicted beat has come back.
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge i_clk);
    endtask

    // Called with the block idle, or during the clearing pass right after reset.
    task automatic write_limit(input logic [3:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        sb.repeat_limit = v;
    endtask

    task automatic directed_reports();
        // never-configured record reads back as all zero apart from its index
        send_report(at_index(5, dstu_pkg::KIND_NONE, dstu_pkg::CODE_NORMAL, 8'hFF, 8'hFF));
        send_report(at_index(0, dstu_pkg::KIND_CURRENT, dstu_pkg::CODE_NORMAL, 8'hFF, 8'hFF));
        send_report(at_index(dstu_pkg::CHANNEL_COUNT - 1, dstu_pkg::KIND_TEMP,
                             dstu_pkg::CODE_NORMAL, 8'h00, 8'h80));
        // out of range: group zero, channel too high, index past the table
        send_report('{11'd0, 8'd0, dstu_pkg::KIND_CURRENT, dstu_pkg::CODE_NORMAL,
                      8'h12, 8'h34});
        send_report('{11'd1, 8'd8, dstu_pkg::KIND_CURRENT, dstu_pkg::CODE_NORMAL,
                      8'h12, 8'h34});
        send_report('{11'h7FF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
        send_report('{11'(dstu_pkg::CHANNEL_COUNT / dstu_pkg::CHANNELS_PER_GROUP + 1), 8'd0,
                      dstu_pkg::KIND_TEMP, dstu_pkg::CODE_NORMAL, 8'h00, 8'h01});
        // repeat counting with limit 1: second report alarms and locks, the fourth
        // alarms again but the held value stays
        send_report(at_index(0, dstu_pkg::KIND_CURRENT, dstu_pkg::CODE_ALARM,  8'h12, 8'h34));
        send_report(at_index(0, dstu_pkg::KIND_CURRENT, dstu_pkg::CODE_REPORT, 8'h56, 8'h78));
        send_report(at_index(0, dstu_pkg::KIND_CURRENT, dstu_pkg::CODE_ALARM,  8'h9A, 8'hBC));
        send_report(at_index(0, dstu_pkg::KIND_CURRENT, dstu_pkg::CODE_ALARM,  8'hDE, 8'hF0));
        // fault keeps alarm, zeroes the reading
        send_report(at_index(0, dstu_pkg::KIND_CURRENT, dstu_pkg::CODE_FAULT, 8'h11, 8'h22));
        send_report(at_index(0, dstu_pkg::KIND_CURRENT, dstu_pkg::CODE_SETPOINT,
                             8'hA5, 8'h5A));
        // same record switched to temperature, its own fields show
        send_report(at_index(0, dstu_pkg::KIND_TEMP, dstu_pkg::CODE_SETPOINT, 8'hEE, 8'h77));
        send_report(at_index(0, dstu_pkg::KIND_TEMP, dstu_pkg::CODE_REPORT, 8'h00, 8'h33));
        send_report(at_index(0, dstu_pkg::KIND_TEMP, dstu_pkg::CODE_ALARM,  8'hFF, 8'h44));
        // kind zero keeps contents but hides values; unknown kind leaves all alone
        send_report(at_index(0, dstu_pkg::KIND_NONE, dstu_pkg::CODE_FAULT, 8'h00, 8'h00));
        send_report(at_index(0, 8'h03, dstu_pkg::CODE_NORMAL, 8'h01, 8'h02));
        send_report(at_index(0, 8'hFF, dstu_pkg::CODE_ALARM, 8'h01, 8'h02));
        // unknown code only stores the kind
        send_report(at_index(0, dstu_pkg::KIND_CURRENT, 8'h04, 8'h01, 8'h02));
        send_report(at_index(0, dstu_pkg::KIND_CURRENT, dstu_pkg::CODE_NORMAL, 8'h00, 8'h00));
        send_report(at_index(dstu_pkg::CHANNEL_COUNT - 1, dstu_pkg::KIND_TEMP,
                             8'hFF, 8'hFF, 8'hFF));
        send_report(at_index(dstu_pkg::CHANNEL_COUNT - 1, dstu_pkg::KIND_TEMP,
                             dstu_pkg::CODE_FAULT, 8'hFF, 8'hFF));
    endtask

    // Mostly alarm bursts on a few busy records so counts cross the limit and locks
    // engage; some single reports over the whole table; a little raw noise.
    task automatic random_reports(input int target);
        int hot[16];
        int stop_at;
        int sel;
        int ix;
        int len;
        logic [7:0]  kind;
        logic [63:0] raw;

        foreach (hot[i]) hot[i] = $urandom_range(0, dstu_pkg::CHANNEL_COUNT - 1);
        hot[0] = 0;
        hot[1] = dstu_pkg::CHANNEL_COUNT - 1;
        stop_at = counted + target;
        while (counted < stop_at) begin
            sel = $urandom_range(0, 99);
            if (sel < 55) begin
                ix   = hot[$urandom_range(0, 15)];
                kind = $urandom_range(0, 1) ? dstu_pkg::KIND_CURRENT : dstu_pkg::KIND_TEMP;
                len  = int'(sb.repeat_limit) + $urandom_range(1, 3);
                repeat (len)
                    send_report(at_index(ix, kind, pick_code(85), 8'($urandom), 8'($urandom)));
            end else if (sel < 85) begin
                send_report(at_index($urandom_range(0, dstu_pkg::CHANNEL_COUNT - 1),
                                     pick_kind(), pick_code(40), 8'($urandom), 8'($urandom)));
            end else begin
                raw = {$urandom, $urandom};
                send_report(t_report'(raw[$bits(t_report)-1:0]));
            end
            // now and then hold the sender until the pipe is empty
            if ($urandom_range(0, 99) == 0) drain();
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_limit(dstu_pkg::LIMIT_RESET);
        directed_reports();
        drain();

        // limits: both extremes, a middle one, then anything in between;
        // the first of these runs with no idling at all
        idle_on = 1'b0;
        write_limit(4'd0);
        random_reports(205);
        drain();
        idle_on = 1'b1;

        write_limit(4'd15);
        random_reports(205);
        drain();

        write_limit(4'd7);
        random_reports(205);
        drain();

        write_limit(4'($urandom_range(2, 14)));
        random_reports(205);
        drain();

        repeat (20) @(posedge i_clk);
        if (sb.mismatch_cnt == 0 && sb.pending_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
